/* rtl/core/bmas_pkg.sv */
// Shared types, field layouts and codes of the bank memory access scheduler.
package bmas_pkg;

   // Field widths fixed by the stream payload
   localparam int CMD_W  = 3;
   localparam int BANK_W = 3;
   localparam int ACC_W  = 2;
   localparam int TAG_W  = 16;
   localparam int OCC_W  = 9;
   localparam int ERR_W  = 2;
   localparam int KINDS  = 3;

   localparam int REQ_BITS    = 25;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_BITS    = 34;
   localparam int RSP_TDATA_W = 40;

   // Default sizing
   localparam int BANK_COUNT_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int READY_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT     = 3'd0,
      CMD_PEEK    = 3'd1,
      CMD_NEXT    = 3'd2,
      CMD_DONE    = 3'd3,
      CMD_RESCHED = 3'd4
   } cmd_type;

   typedef enum logic [ACC_W-1:0] {
      ACC_FETCH     = 2'd0,
      ACC_LOAD      = 2'd1,
      ACC_STORE     = 2'd2,
      ACC_WRITEBACK = 2'd3
   } acc_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK         = 2'd0,
      ERR_FULL       = 2'd1,
      ERR_EMPTY      = 2'd2,
      ERR_READY_FULL = 2'd3
   } err_type;

   // Queue kinds inside one bank (writebacks share the store queue)
   localparam logic [1:0] KIND_FETCH = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_STORE = 2'd2;

   // Request payload, last field in the lowest bits
   typedef struct packed {
      logic              pending;
      logic [TAG_W-1:0]  tag;
      acc_type           acc;
      logic [BANK_W-1:0] bank;
      cmd_type           cmd;
   } req_type;

   // Response payload, last field in the lowest bits
   typedef struct packed {
      err_type           err;
      logic [OCC_W-1:0]  occupancy;
      logic              waiting;
      logic [BANK_W-1:0] bank;
      acc_type           otype;
      logic [TAG_W-1:0]  tag;
      logic              valid;
   } rsp_type;

   // Decision of the scheduling stage, carried to the result stage
   typedef struct packed {
      logic             valid;
      logic             peek;
      logic             pop;
      logic [1:0]       kind;
      logic             waiting;
      logic [OCC_W-1:0] occupancy;
      err_type          err;
   } info_type;

endpackage

/* rtl/core/bmas_ram.sv */
// Generic simple dual-port RAM with registered read.
module bmas_ram #(
   parameter int WIDTH = bmas_pkg::TAG_W,
   parameter int DEPTH = bmas_pkg::QUEUE_DEPTH_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bmas_bank_state.sv */
// Per-bank queue counts and head pointers: RAM rows with valid bits and write forwarding.
module bmas_bank_state #(
   parameter int ROWS  = bmas_pkg::BANK_COUNT_DEF,
   parameter int CNT_W = 5,
   parameter int PTR_W = 4,
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int ROW_W  = bmas_pkg::KINDS * (CNT_W + PTR_W)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [ROW_AW-1:0]                    rd_row,
   input  logic                                 wr_en,
   input  logic [ROW_AW-1:0]                    wr_row,
   input  logic [bmas_pkg::KINDS-1:0][CNT_W-1:0] wr_cnt,
   input  logic [bmas_pkg::KINDS-1:0][PTR_W-1:0] wr_hd,
   output logic [bmas_pkg::KINDS-1:0][CNT_W-1:0] rd_cnt,
   output logic [bmas_pkg::KINDS-1:0][PTR_W-1:0] rd_hd
);

   logic [ROWS-1:0]                          vld_ff;
   logic                                     rd_vld_ff;
   logic                                     fwd_ff;
   logic [bmas_pkg::KINDS-1:0][CNT_W-1:0]    fwd_cnt_ff;
   logic [bmas_pkg::KINDS-1:0][PTR_W-1:0]    fwd_hd_ff;
   logic [ROW_W-1:0]                         ram_rd;
   logic                                     rd_in_range;

   bmas_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row),
      .wr_data ({wr_hd, wr_cnt}),
      .rd_en   (rd_en),
      .rd_addr (rd_row),
      .rd_data (ram_rd)
   );

   assign rd_in_range = (int'(rd_row) < ROWS);

   // Track written rows; flag a read that races a write to the same row
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_row] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= rd_in_range && vld_ff[rd_row];
            fwd_ff    <= wr_en && (wr_row == rd_row);
         end
      end
   end

   // Hold the row written at the read edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_cnt_ff <= wr_cnt;
         fwd_hd_ff  <= wr_hd;
      end
   end

   // Select forwarded, stored or reset row
   always_comb begin
      if (fwd_ff) begin
         rd_cnt = fwd_cnt_ff;
         rd_hd  = fwd_hd_ff;
      end else if (rd_vld_ff) begin
         {rd_hd, rd_cnt} = ram_rd;
      end else begin
         rd_cnt = '0;
         rd_hd  = '0;
      end
   end

endmodule

/* rtl/core/bmas_sched.sv */
// Scheduling stage: decodes a command, updates queue and ready-list state, drives RAM ports.
module bmas_sched #(
   parameter int QUEUE_DEPTH = bmas_pkg::QUEUE_DEPTH_DEF,
   parameter int READY_DEPTH = bmas_pkg::READY_DEPTH_DEF,
   parameter int ROWS        = bmas_pkg::BANK_COUNT_DEF,
   parameter int TW          = bmas_pkg::TAG_BITS_DEF,
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
   localparam int PTR_W  = $clog2(QUEUE_DEPTH),
   localparam int MAW    = $clog2(ROWS * QUEUE_DEPTH),
   localparam int RD_CW  = $clog2(READY_DEPTH + 1),
   localparam int RD_PW  = $clog2(READY_DEPTH),
   localparam int TOT_W  = $clog2(bmas_pkg::KINDS * ROWS * QUEUE_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 item_vld,
   input  bmas_pkg::req_type                    req,
   input  logic [bmas_pkg::KINDS-1:0][CNT_W-1:0] rd_cnt,
   input  logic [bmas_pkg::KINDS-1:0][PTR_W-1:0] rd_hd,
   output logic                                 row_wr_en,
   output logic [bmas_pkg::KINDS-1:0][CNT_W-1:0] row_wr_cnt,
   output logic [bmas_pkg::KINDS-1:0][PTR_W-1:0] row_wr_hd,
   output logic [bmas_pkg::KINDS-1:0]           tag_wr_en,
   output logic [MAW-1:0]                       tag_wr_addr,
   output logic [TW:0]                          tag_wr_data,
   output logic [bmas_pkg::KINDS-1:0][MAW-1:0]  tag_rd_addr,
   output logic [bmas_pkg::BANK_W-1:0]          ready_bank,
   output bmas_pkg::info_type                   info
);

   localparam int OCC_OUT_W = bmas_pkg::OCC_W;

   logic [RD_PW-1:0]  rdy_head_ff, rdy_head_in;
   logic [RD_CW-1:0]  rdy_cnt_ff, rdy_cnt_in;
   logic [TOT_W-1:0]  total_ff, total_in;

   logic              commit;
   logic [1:0]        kind;
   logic              bank_ok;
   logic [CNT_W+1:0]  bank_sum;
   logic [CNT_W:0]    slot_sum;
   logic [PTR_W-1:0]  slot;
   logic [PTR_W:0]    hd_inc_sum;
   logic [PTR_W-1:0]  hd_inc;
   logic [RD_CW:0]    tail_sum;
   logic [RD_PW-1:0]  rdy_tail;
   logic [RD_PW:0]    rh_inc_sum;
   logic [RD_PW-1:0]  rh_inc;
   logic [MAW-1:0]    bank_base;
   logic              row_change;
   logic              tag_we;
   logic              push;
   logic              push_ok;
   logic              pop;
   logic              found;
   logic [1:0]        kind_sel;
   bmas_pkg::err_type err;

   assign commit = advance && item_vld;

   // Address arithmetic and wraparounds
   always_comb begin
      kind = (req.acc == bmas_pkg::ACC_WRITEBACK) ? bmas_pkg::KIND_STORE : 2'(req.acc);
      bank_ok  = (int'(req.bank) < ROWS);
      bank_sum = (CNT_W+2)'(rd_cnt[0]) + (CNT_W+2)'(rd_cnt[1]) + (CNT_W+2)'(rd_cnt[2]);

      slot_sum = (CNT_W+1)'(rd_hd[kind]) + (CNT_W+1)'(rd_cnt[kind]);
      if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         slot_sum = slot_sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      slot = slot_sum[PTR_W-1:0];

      hd_inc_sum = (PTR_W+1)'(rd_hd[kind]) + (PTR_W+1)'(1);
      hd_inc     = (hd_inc_sum == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : hd_inc_sum[PTR_W-1:0];

      tail_sum = (RD_CW+1)'(rdy_head_ff) + (RD_CW+1)'(rdy_cnt_ff);
      if (tail_sum >= (RD_CW+1)'(READY_DEPTH)) begin
         tail_sum = tail_sum - (RD_CW+1)'(READY_DEPTH);
      end
      rdy_tail = tail_sum[RD_PW-1:0];

      rh_inc_sum = (RD_PW+1)'(rdy_head_ff) + (RD_PW+1)'(1);
      rh_inc     = (rh_inc_sum == (RD_PW+1)'(READY_DEPTH)) ? '0 : rh_inc_sum[RD_PW-1:0];

      bank_base = MAW'(int'(req.bank) * QUEUE_DEPTH);
   end

   // Command decode and state next values
   always_comb begin
      row_wr_cnt = rd_cnt;
      row_wr_hd  = rd_hd;
      row_change = 1'b0;
      tag_we     = 1'b0;
      push       = 1'b0;
      pop        = 1'b0;
      found      = 1'b0;
      kind_sel   = bmas_pkg::KIND_FETCH;
      total_in   = total_ff;
      err        = bmas_pkg::ERR_OK;

      case (req.cmd)
         bmas_pkg::CMD_PUT: begin
            if (!bank_ok || (rd_cnt[kind] >= CNT_W'(QUEUE_DEPTH))) begin
               err = bmas_pkg::ERR_FULL;
            end else begin
               tag_we           = 1'b1;
               row_change       = 1'b1;
               row_wr_cnt[kind] = rd_cnt[kind] + CNT_W'(1);
               total_in         = total_ff + TOT_W'(1);
               push             = (bank_sum == '0) && !req.pending;
            end
         end
         bmas_pkg::CMD_PEEK: begin
            if (bank_ok) begin
               if (rd_cnt[0] != '0) begin
                  found    = 1'b1;
                  kind_sel = bmas_pkg::KIND_FETCH;
               end else if (rd_cnt[1] != '0) begin
                  found    = 1'b1;
                  kind_sel = bmas_pkg::KIND_LOAD;
               end else if (rd_cnt[2] != '0) begin
                  found    = 1'b1;
                  kind_sel = bmas_pkg::KIND_STORE;
               end
            end
         end
         bmas_pkg::CMD_NEXT: begin
            if (rdy_cnt_ff == '0) begin
               err = bmas_pkg::ERR_EMPTY;
            end else begin
               found = 1'b1;
               pop   = 1'b1;
            end
         end
         bmas_pkg::CMD_DONE: begin
            if (!bank_ok || (rd_cnt[kind] == '0)) begin
               err = bmas_pkg::ERR_EMPTY;
            end else begin
               row_change       = 1'b1;
               row_wr_hd[kind]  = hd_inc;
               row_wr_cnt[kind] = rd_cnt[kind] - CNT_W'(1);
               total_in         = total_ff - TOT_W'(1);
            end
         end
         bmas_pkg::CMD_RESCHED: begin
            push = bank_ok && (bank_sum != '0);
         end
         default: begin
         end
      endcase

      // Drop a ready-list push when the list is full
      push_ok = push && (rdy_cnt_ff < RD_CW'(READY_DEPTH));
      if (push && !push_ok) begin
         err = bmas_pkg::ERR_READY_FULL;
      end

      rdy_head_in = pop ? rh_inc : rdy_head_ff;
      if (push_ok) begin
         rdy_cnt_in = rdy_cnt_ff + RD_CW'(1);
      end else if (pop) begin
         rdy_cnt_in = rdy_cnt_ff - RD_CW'(1);
      end else begin
         rdy_cnt_in = rdy_cnt_ff;
      end
   end

   // Commit scalar state
   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_head_ff <= '0;
         rdy_cnt_ff  <= '0;
         total_ff    <= '0;
      end else if (commit) begin
         rdy_head_ff <= rdy_head_in;
         rdy_cnt_ff  <= rdy_cnt_in;
         total_ff    <= total_in;
      end
   end

   // RAM port drive
   always_comb begin
      row_wr_en   = commit && row_change;
      tag_wr_en   = '0;
      tag_wr_en[kind] = commit && tag_we;
      tag_wr_addr = bank_base + MAW'(slot);
      tag_wr_data = {(req.acc == bmas_pkg::ACC_WRITEBACK), req.tag[TW-1:0]};
      for (int k = 0; k < bmas_pkg::KINDS; k++) begin
         tag_rd_addr[k] = bank_base + MAW'(rd_hd[k]);
      end
   end

   // Ready-bank list
   bmas_ram #(
      .WIDTH(bmas_pkg::BANK_W),
      .DEPTH(READY_DEPTH)
   ) u_ready_ram (
      .clock   (clock),
      .wr_en   (commit && push_ok),
      .wr_addr (rdy_tail),
      .wr_data (req.bank),
      .rd_en   (advance),
      .rd_addr (rdy_head_ff),
      .rd_data (ready_bank)
   );

   // Decision for the result stage
   always_comb begin
      info.valid     = found;
      info.peek      = (req.cmd == bmas_pkg::CMD_PEEK);
      info.pop       = pop;
      info.kind      = kind_sel;
      info.waiting   = (rdy_cnt_in != '0);
      info.occupancy = OCC_OUT_W'(total_in);
      info.err       = err;
   end

endmodule

/* rtl/core/bank_memory_access_scheduler.sv */
// Top level of the bank memory access scheduler: pipeline registers, tag RAMs, result assembly.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | req_tdata: command, bank, type, tag, pending
//   rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: valid, tag, type, bank, waiting,
//           |           |                       |            occupancy, error code
//
// One transaction per cycle while rsp does not stall; results leave in request order.
// The pipe is input register, scheduling stage (queue RAM reads registered), result register.
// A low rsp_tready with a result waiting holds every stage and drops req_tready.
// Reset clears the per-bank row valid bits and the counters at once; no clearing pass.
// req_tready stays low while reset is high.
module bank_memory_access_scheduler #(
   parameter int BANK_COUNT  = bmas_pkg::BANK_COUNT_DEF,
   parameter int QUEUE_DEPTH = bmas_pkg::QUEUE_DEPTH_DEF,
   parameter int READY_DEPTH = bmas_pkg::READY_DEPTH_DEF,
   parameter int TAG_BITS    = bmas_pkg::TAG_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] command, [5:3] bank, [7:6] access_type, [23:8] request_tag,
   // [24] bank_pending, [31:25] zero
   input  logic [bmas_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] result_valid, [16:1] out_tag, [18:17] out_type, [21:19] out_bank,
   // [22] banks_waiting, [31:23] occupancy, [33:32] error_code, [39:34] zero
   output logic [bmas_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ROWS      = (BANK_COUNT < 8) ? BANK_COUNT : 8;
   localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int TW        = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int MDEPTH    = ROWS * QUEUE_DEPTH;
   localparam int MAW       = $clog2(MDEPTH);
   localparam int TAG_OUT_W = bmas_pkg::TAG_W;

   logic                                  advance;
   bmas_pkg::req_type                     req_in;

   logic                                  in_vld_ff;
   bmas_pkg::req_type                     in_req_ff;
   logic                                  p1_vld_ff;
   bmas_pkg::info_type                    p1_info_ff;
   logic                                  rsp_vld_ff;
   bmas_pkg::rsp_type                     rsp_ff, rsp_in;

   logic [bmas_pkg::KINDS-1:0][CNT_W-1:0] rd_cnt;
   logic [bmas_pkg::KINDS-1:0][PTR_W-1:0] rd_hd;
   logic                                  row_wr_en;
   logic [bmas_pkg::KINDS-1:0][CNT_W-1:0] row_wr_cnt;
   logic [bmas_pkg::KINDS-1:0][PTR_W-1:0] row_wr_hd;
   logic [bmas_pkg::KINDS-1:0]            tag_wr_en;
   logic [MAW-1:0]                        tag_wr_addr;
   logic [TW:0]                           tag_wr_data;
   logic [bmas_pkg::KINDS-1:0][MAW-1:0]   tag_rd_addr;
   logic [bmas_pkg::BANK_W-1:0]           ready_bank;
   bmas_pkg::info_type                    info;

   logic [TW-1:0]                         fetch_rd;
   logic [TW-1:0]                         load_rd;
   logic [TW:0]                           store_rd;

   // Whole pipe moves when the result register is free
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance && !reset;
   assign req_in     = bmas_pkg::req_type'(req_tdata[bmas_pkg::REQ_BITS-1:0]);

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff  <= req_tvalid;
         p1_vld_ff  <= in_vld_ff;
         rsp_vld_ff <= p1_vld_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         in_req_ff  <= req_in;
         p1_info_ff <= info;
         rsp_ff     <= rsp_in;
      end
   end

   // Row read is issued with the transaction so it is ready in the scheduling stage
   bmas_bank_state #(
      .ROWS  (ROWS),
      .CNT_W (CNT_W),
      .PTR_W (PTR_W)
   ) u_bank_state (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (advance),
      .rd_row (req_in.bank[ROW_AW-1:0]),
      .wr_en  (row_wr_en),
      .wr_row (in_req_ff.bank[ROW_AW-1:0]),
      .wr_cnt (row_wr_cnt),
      .wr_hd  (row_wr_hd),
      .rd_cnt (rd_cnt),
      .rd_hd  (rd_hd)
   );

   bmas_sched #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .READY_DEPTH (READY_DEPTH),
      .ROWS        (ROWS),
      .TW          (TW)
   ) u_sched (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item_vld    (in_vld_ff),
      .req         (in_req_ff),
      .rd_cnt      (rd_cnt),
      .rd_hd       (rd_hd),
      .row_wr_en   (row_wr_en),
      .row_wr_cnt  (row_wr_cnt),
      .row_wr_hd   (row_wr_hd),
      .tag_wr_en   (tag_wr_en),
      .tag_wr_addr (tag_wr_addr),
      .tag_wr_data (tag_wr_data),
      .tag_rd_addr (tag_rd_addr),
      .ready_bank  (ready_bank),
      .info        (info)
   );

   // Tag queues, one RAM per kind; the store queue keeps a writeback bit
   bmas_ram #(
      .WIDTH(TW),
      .DEPTH(MDEPTH)
   ) u_fetch_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en[bmas_pkg::KIND_FETCH]),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data[TW-1:0]),
      .rd_en   (advance),
      .rd_addr (tag_rd_addr[bmas_pkg::KIND_FETCH]),
      .rd_data (fetch_rd)
   );

   bmas_ram #(
      .WIDTH(TW),
      .DEPTH(MDEPTH)
   ) u_load_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en[bmas_pkg::KIND_LOAD]),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data[TW-1:0]),
      .rd_en   (advance),
      .rd_addr (tag_rd_addr[bmas_pkg::KIND_LOAD]),
      .rd_data (load_rd)
   );

   bmas_ram #(
      .WIDTH(TW + 1),
      .DEPTH(MDEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en[bmas_pkg::KIND_STORE]),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (advance),
      .rd_addr (tag_rd_addr[bmas_pkg::KIND_STORE]),
      .rd_data (store_rd)
   );

   // Assemble the result from the decision and the registered RAM reads
   always_comb begin
      rsp_in           = '0;
      rsp_in.valid     = p1_info_ff.valid;
      rsp_in.waiting   = p1_info_ff.waiting;
      rsp_in.occupancy = p1_info_ff.occupancy;
      rsp_in.err       = p1_info_ff.err;
      if (p1_info_ff.valid && p1_info_ff.peek) begin
         case (p1_info_ff.kind)
            bmas_pkg::KIND_FETCH: begin
               rsp_in.tag   = TAG_OUT_W'(fetch_rd);
               rsp_in.otype = bmas_pkg::ACC_FETCH;
            end
            bmas_pkg::KIND_LOAD: begin
               rsp_in.tag   = TAG_OUT_W'(load_rd);
               rsp_in.otype = bmas_pkg::ACC_LOAD;
            end
            default: begin
               rsp_in.tag   = TAG_OUT_W'(store_rd[TW-1:0]);
               rsp_in.otype = store_rd[TW] ? bmas_pkg::ACC_WRITEBACK : bmas_pkg::ACC_STORE;
            end
         endcase
      end
      if (p1_info_ff.valid && p1_info_ff.pop) begin
         rsp_in.bank = ready_bank;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(bmas_pkg::RSP_TDATA_W - bmas_pkg::RSP_BITS)'(0), rsp_ff};

endmodule

/* rtl/core/bmas_checker.sv */
// Port-level checker for the bank memory access scheduler, bound to the top level.
module bmas_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bmas_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result holds its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // An empty result register never back-pressures the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with no result waiting");

   // A found request or bank comes with no error
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[33:32] == bmas_pkg::ERR_OK)
      else $error("valid result reported an error");

   // Without a find, tag, type and bank read zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[21:1] == 21'd0)
      else $error("payload fields set without a valid result");

endmodule

bind bank_memory_access_scheduler bmas_checker u_bmas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
